@@ hw/rtl/boxds_pkg.sv @@
package boxds_pkg;

	// default build limits
	localparam int DEF_MAX_BLOCK_WIDTH  = 16;
	localparam int DEF_MAX_BLOCK_HEIGHT = 16;
	localparam int DEF_MAX_DST_WIDTH    = 1024;

	// fixed limits of the source and output frame
	localparam int SRC_LIMIT        = 16384;
	localparam int SRC_W            = 14;
	localparam int DST_HEIGHT_LIMIT = 1024;
	localparam int OUT_ROW_W        = $clog2(DST_HEIGHT_LIMIT + 1);

	localparam int CFG_ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_SRC_WIDTH,
		REG_SRC_HEIGHT,
		REG_BLOCK_WIDTH,
		REG_BLOCK_HEIGHT,
		REG_DST_WIDTH,
		REG_DST_HEIGHT
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
		logic [7:0] in_alpha;
	} pix_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic       frame_done;
	} res_t;

	typedef struct packed {
		logic [14:0] src_width;
		logic [14:0] src_height;
		logic [4:0]  block_width;
		logic [4:0]  block_height;
		logic [10:0] dst_width;
		logic [10:0] dst_height;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic write;
		logic div_start;
		logic out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic rmw;
		logic need_div;
		logic div_busy;
		logic out_free;
	} status_t;

	// zero counts as one, anything above the limit is the limit
	function automatic logic [31:0] clamp_reg(input logic [31:0] v, input logic [31:0] lim);
		return (v == 32'd0) ? 32'd1 : ((v > lim) ? lim : v);
	endfunction

endpackage

@@ hw/rtl/boxds_ram.sv @@
module boxds_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/boxds_regs.sv @@
module boxds_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [boxds_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output boxds_pkg::cfg_t                   cfg
);
	import boxds_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width    <= 15'd1;
			cfg_q.src_height   <= 15'd1;
			cfg_q.block_width  <= 5'd1;
			cfg_q.block_height <= 5'd1;
			cfg_q.dst_width    <= 11'd1;
			cfg_q.dst_height   <= 11'd1;
		end else if (wr) begin
			case (idx)
				REG_SRC_WIDTH:    cfg_q.src_width    <= pwdata[14:0];
				REG_SRC_HEIGHT:   cfg_q.src_height   <= pwdata[14:0];
				REG_BLOCK_WIDTH:  cfg_q.block_width  <= pwdata[4:0];
				REG_BLOCK_HEIGHT: cfg_q.block_height <= pwdata[4:0];
				REG_DST_WIDTH:    cfg_q.dst_width    <= pwdata[10:0];
				REG_DST_HEIGHT:   cfg_q.dst_height   <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SRC_WIDTH:    prdata = 32'(cfg_q.src_width);
			REG_SRC_HEIGHT:   prdata = 32'(cfg_q.src_height);
			REG_BLOCK_WIDTH:  prdata = 32'(cfg_q.block_width);
			REG_BLOCK_HEIGHT: prdata = 32'(cfg_q.block_height);
			REG_DST_WIDTH:    prdata = 32'(cfg_q.dst_width);
			REG_DST_HEIGHT:   prdata = 32'(cfg_q.dst_height);
			default:          prdata = 32'd0;
		endcase
	end

endmodule

@@ hw/rtl/boxds_div.sv @@
// four-lane restoring divider, one quotient bit per cycle, shared count
module boxds_div #(
	parameter int DD_W = 18,
	parameter int DV_W = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [3:0][DD_W-1:0]  dividend,
	input  logic [DV_W-1:0]       divisor,
	output logic                  busy,
	output logic [3:0][7:0]       quot
);

	localparam int CNT_W = $clog2(DD_W + 1);

	logic [CNT_W-1:0]      cnt_q;
	logic [3:0][DD_W-1:0]  dvd_q;
	logic [3:0][DV_W-1:0]  rem_q;
	logic [3:0][7:0]       quot_q;
	logic [DV_W-1:0]       dvs_q;

	logic [3:0][DV_W:0]    rem_sh;
	logic [3:0][DV_W-1:0]  rem_nx;
	logic [3:0]            ge;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			rem_sh[l] = {rem_q[l], dvd_q[l][DD_W-1]};
			ge[l]     = rem_sh[l] >= {1'b0, dvs_q};
			rem_nx[l] = ge[l] ? DV_W'(rem_sh[l] - {1'b0, dvs_q}) : DV_W'(rem_sh[l]);
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DD_W);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			dvs_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy) begin
			for (int l = 0; l < 4; l++) begin
				dvd_q[l]  <= {dvd_q[l][DD_W-2:0], 1'b0};
				rem_q[l]  <= rem_nx[l];
				quot_q[l] <= {quot_q[l][6:0], ge[l]};
			end
		end
	end

endmodule

@@ hw/rtl/boxds_dp.sv @@
module boxds_dp #(
	parameter int MAX_BLOCK_WIDTH  = boxds_pkg::DEF_MAX_BLOCK_WIDTH,
	parameter int MAX_BLOCK_HEIGHT = boxds_pkg::DEF_MAX_BLOCK_HEIGHT,
	parameter int MAX_DST_WIDTH    = boxds_pkg::DEF_MAX_DST_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  boxds_pkg::cfg_t     cfg,
	input  boxds_pkg::pix_t     in_data,
	input  boxds_pkg::cmd_t     cmd,
	output boxds_pkg::status_t  st,
	output logic                out_valid,
	input  logic                out_stall,
	output boxds_pkg::res_t     out_data
);
	import boxds_pkg::*;

	localparam int SW_W  = SRC_W + 1;
	localparam int BW_W  = $clog2(MAX_BLOCK_WIDTH + 1);
	localparam int BH_W  = $clog2(MAX_BLOCK_HEIGHT + 1);
	localparam int CB_W  = (MAX_BLOCK_WIDTH > 1) ? $clog2(MAX_BLOCK_WIDTH) : 1;
	localparam int RB_W  = (MAX_BLOCK_HEIGHT > 1) ? $clog2(MAX_BLOCK_HEIGHT) : 1;
	localparam int OC_W  = $clog2(MAX_DST_WIDTH + 1);
	localparam int IDX_W = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
	localparam int N_W   = $clog2(MAX_BLOCK_WIDTH * MAX_BLOCK_HEIGHT + 1);
	localparam int RP_W  = $clog2(255 * MAX_BLOCK_WIDTH + 1);
	localparam int SUM_W = $clog2(255 * MAX_BLOCK_WIDTH * MAX_BLOCK_HEIGHT + 1);
	localparam int DD_W  = SUM_W + 2;
	localparam int DV_W  = N_W + 1;
	localparam int PC_W  = OC_W + BW_W + 1;
	localparam int PR_W  = OUT_ROW_W + BH_W + 1;

	// effective register values
	logic [SW_W-1:0]      sw, sh;
	logic [BW_W-1:0]      bw;
	logic [BH_W-1:0]      bh;
	logic [OC_W-1:0]      dst_c;
	logic [OUT_ROW_W-1:0] dh_c;
	logic [N_W-1:0]       n;

	assign sw    = SW_W'(clamp_reg(32'(cfg.src_width), 32'(SRC_LIMIT)));
	assign sh    = SW_W'(clamp_reg(32'(cfg.src_height), 32'(SRC_LIMIT)));
	assign bw    = BW_W'(clamp_reg(32'(cfg.block_width), 32'(MAX_BLOCK_WIDTH)));
	assign bh    = BH_W'(clamp_reg(32'(cfg.block_height), 32'(MAX_BLOCK_HEIGHT)));
	assign dst_c = OC_W'(clamp_reg(32'(cfg.dst_width), 32'(MAX_DST_WIDTH)));
	assign dh_c  = OUT_ROW_W'(clamp_reg(32'(cfg.dst_height), 32'(DST_HEIGHT_LIMIT)));
	assign n     = N_W'(bw) * N_W'(bh);

	// raster position
	logic [SRC_W-1:0]          src_col_q, src_row_q;
	logic [CB_W-1:0]           cib_q;
	logic [RB_W-1:0]           rib_q;
	logic [OC_W-1:0]           out_col_q;
	logic [OUT_ROW_W-1:0]      out_row_q;
	logic [3:0][RP_W-1:0]      rp_q;

	logic [3:0][7:0]           pix;
	logic [3:0][RP_W-1:0]      psum;
	logic                      row_end, last_row, h_end, bh_end, v_end;
	logic                      act_col, act_row, active, col_last, row_last;
	logic [PC_W-1:0]           col_prod, col_prod_nx;
	logic [PR_W-1:0]           row_prod, row_prod_nx;

	assign pix = {in_data.in_alpha, in_data.in_blue, in_data.in_green, in_data.in_red};

	assign row_end  = 32'(src_col_q) + 32'd1 >= 32'(sw);
	assign last_row = 32'(src_row_q) + 32'd1 >= 32'(sh);
	assign h_end    = (32'(cib_q) + 32'd1 >= 32'(bw)) || row_end;
	assign bh_end   = 32'(rib_q) + 32'd1 >= 32'(bh);
	assign v_end    = bh_end || last_row;

	// out_col < ceil(sw/bw) without a divide: out_col*bw < sw
	assign col_prod    = PC_W'(out_col_q) * PC_W'(bw);
	assign col_prod_nx = col_prod + PC_W'(bw);
	assign row_prod    = PR_W'(out_row_q) * PR_W'(bh);
	assign row_prod_nx = row_prod + PR_W'(bh);

	assign act_col  = (out_col_q < dst_c) && (32'(col_prod) < 32'(sw));
	assign act_row  = (out_row_q < dh_c) && (32'(row_prod) < 32'(sh));
	assign active   = act_col && act_row;
	assign col_last = (32'(out_col_q) + 32'd1 >= 32'(dst_c)) || (32'(col_prod_nx) >= 32'(sw));
	assign row_last = (32'(out_row_q) + 32'd1 >= 32'(dh_c)) || (32'(row_prod_nx) >= 32'(sh));

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			psum[c] = rp_q[c] + (active ? RP_W'(pix[c]) : RP_W'(0));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			cib_q     <= '0;
			rib_q     <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			rp_q      <= '0;
		end else if (cmd.accept) begin
			rp_q <= h_end ? '0 : psum;
			if (row_end) begin
				src_col_q <= '0;
				cib_q     <= '0;
				out_col_q <= '0;
				if (last_row) begin
					src_row_q <= '0;
					rib_q     <= '0;
					out_row_q <= '0;
				end else begin
					src_row_q <= src_row_q + SRC_W'(1);
					if (bh_end) begin
						rib_q <= '0;
						if (act_row) begin
							out_row_q <= out_row_q + OUT_ROW_W'(1);
						end
					end else begin
						rib_q <= rib_q + RB_W'(1);
					end
				end
			end else begin
				src_col_q <= src_col_q + SRC_W'(1);
				if (h_end) begin
					cib_q <= '0;
					if (act_col) begin
						out_col_q <= out_col_q + OC_W'(1);
					end
				end else begin
					cib_q <= cib_q + CB_W'(1);
				end
			end
		end
	end

	// block-segment capture for the column-sum update
	logic [3:0][RP_W-1:0] part_s1;
	logic [IDX_W-1:0]     col_s1;
	logic                 add_s1, v_s1, last_s1;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			part_s1 <= psum;
			col_s1  <= out_col_q[IDX_W-1:0];
			add_s1  <= rib_q != '0;
			v_s1    <= v_end;
			last_s1 <= col_last && row_last;
		end
	end

	// column sums: read at accept, written back in the cycle after
	logic [3:0][SUM_W-1:0] rdata, wsum;
	logic [3:0][DD_W-1:0]  dividend;
	logic [DV_W-1:0]       divisor;

	boxds_ram #(
		.WIDTH (4 * SUM_W),
		.DEPTH (MAX_DST_WIDTH)
	) u_colsum (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (col_s1),
		.wdata (wsum),
		.re    (cmd.accept),
		.raddr (out_col_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			wsum[c]     = SUM_W'(part_s1[c]) + (add_s1 ? rdata[c] : SUM_W'(0));
			dividend[c] = DD_W'({wsum[c], 1'b0}) + DD_W'(n);
		end
	end

	assign divisor = {n, 1'b0};

	// round half up: floor((2s + n) / 2n)
	logic            div_busy;
	logic [3:0][7:0] quot;

	boxds_div #(
		.DD_W (DD_W),
		.DV_W (DV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.busy     (div_busy),
		.quot     (quot)
	);

	// output register
	logic out_valid_q;
	res_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q.out_red    <= quot[0];
			out_data_q.out_green  <= quot[1];
			out_data_q.out_blue   <= quot[2];
			out_data_q.out_alpha  <= quot[3];
			out_data_q.frame_done <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign st.rmw      = h_end && active;
	assign st.need_div = v_s1;
	assign st.div_busy = div_busy;
	assign st.out_free = !out_valid_q || !out_stall;

endmodule

@@ hw/rtl/boxds_ctrl.sv @@
module boxds_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  boxds_pkg::status_t  st,
	output boxds_pkg::cmd_t     cmd
);
	import boxds_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RMW,
		S_DIV,
		S_OUT
	} state_t;

	state_t state_q, state_nx;
	logic   in_stall_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && st.rmw) begin
					state_nx = S_RMW;
				end
			end
			S_RMW: begin
				cmd.write = 1'b1;
				if (st.need_div) begin
					cmd.div_start = 1'b1;
					state_nx      = S_DIV;
				end else begin
					state_nx = S_IDLE;
				end
			end
			S_DIV: begin
				if (!st.div_busy) begin
					state_nx = S_OUT;
				end
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			state_q    <= state_nx;
			in_stall_q <= state_nx != S_IDLE;
		end
	end

	assign in_stall = in_stall_q;

endmodule

@@ hw/rtl/box_average_downscaler_core.sv @@
// Box-average downscaler for an RGBA raster stream. Source pixels enter in
// raster order on the in channel; each channel is summed over non-overlapping
// block_width x block_height blocks and one rounded mean pixel per block leaves
// on the out channel, with frame_done set on the last pixel of the frame.
// Blocks cut by the right or bottom edge are still divided by the full block
// area; pixels beyond the covered blocks are dropped. Registers sit on the
// APB port at 4*index (src_width, src_height, block_width, block_height,
// dst_width, dst_height). The user must see that registers are written only
// while no transfer is in flight; the block itself does not enforce this.
// A pixel that does not close a block row segment, or that lies outside the
// covered blocks, does not stall the input. A covered pixel that closes one
// reads the column-sum RAM, then stalls the input for the read-modify-write.
// A pixel that completes a block also stalls it while the bit-serial divider
// forms the four rounded means in parallel, and while the output register
// waits on stall.
// The output register lets a finished pixel wait while new pixels come in.
module box_average_downscaler_core #(
	parameter int MAX_BLOCK_WIDTH  = boxds_pkg::DEF_MAX_BLOCK_WIDTH,
	parameter int MAX_BLOCK_HEIGHT = boxds_pkg::DEF_MAX_BLOCK_HEIGHT,
	parameter int MAX_DST_WIDTH    = boxds_pkg::DEF_MAX_DST_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,

	// pixel in
	input  logic                             in_valid,
	output logic                             in_stall,
	input  boxds_pkg::pix_t                  in_data,

	// block mean out
	output logic                             out_valid,
	input  logic                             out_stall,
	output boxds_pkg::res_t                  out_data,

	// register port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [boxds_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import boxds_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t st;

	// register file
	boxds_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: accept, column-sum update, divide, hand to output register
	boxds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// counters, row partials, column-sum RAM, divider, output register
	boxds_dp #(
		.MAX_BLOCK_WIDTH  (MAX_BLOCK_WIDTH),
		.MAX_BLOCK_HEIGHT (MAX_BLOCK_HEIGHT),
		.MAX_DST_WIDTH    (MAX_DST_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_data   (in_data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
